// ===== hdl/cmrg_pkg.sv =====
// Shared types, constants and helpers for the channel mean-ratio gain correction core.
`default_nettype none

package cmrg_pkg;

    localparam int NUM_CH              = 3;
    localparam int PIX_W               = 8;
    localparam int SUM_W               = 30;
    localparam int GAIN_W              = 24;
    localparam int PROD_W              = PIX_W + GAIN_W;
    localparam int GAIN_FRAC_BITS_DEF  = 16;
    localparam int MID_DEPTH_DEF       = 4;
    localparam int RES_DEPTH_DEF       = 4;

    localparam logic [PIX_W-1:0]  PIX_MAX  = 8'd255;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    // Operation codes of an input item
    localparam logic OP_ACCUM   = 1'b0;
    localparam logic OP_CORRECT = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] proc_c0;
        logic [PIX_W-1:0] proc_c1;
        logic [PIX_W-1:0] proc_c2;
        logic [PIX_W-1:0] ref_c0;
        logic [PIX_W-1:0] ref_c1;
        logic [PIX_W-1:0] ref_c2;
        logic             frame_end;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_c0;
        logic [PIX_W-1:0] out_c1;
        logic [PIX_W-1:0] out_c2;
    } out_item_t;

    // Command kinds passed from front to back
    typedef enum logic [0:0] {
        CMD_CORRECT = 1'b0,
        CMD_GAIN    = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        logic [NUM_CH-1:0][PIX_W-1:0] pix;
    } cmd_t;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] proc;
        logic [NUM_CH-1:0][SUM_W-1:0] refr;
    } sum_set_t;

    // Saturating add of one pixel into a running sum
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [PIX_W-1:0] pix);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W+1)'(pix);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cmrg_fifo.sv =====
// Small register-based first-in first-out queue.
`default_nettype none

module cmrg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    output logic [WIDTH-1:0]         rd_data,
    output logic                     full,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cmrg_front.sv =====
// Front end: accepts items, keeps the channel sums and issues commands to the back end.
`default_nettype none

module cmrg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  cmrg_pkg::in_item_t  item,
    input  logic                push,
    output logic                full,
    input  logic                mid_full,
    output logic                mid_push,
    output cmrg_pkg::cmd_t      mid_data,
    output cmrg_pkg::sum_set_t  snap,
    input  logic                snap_free
);

    import cmrg_pkg::*;

    logic [NUM_CH-1:0][PIX_W-1:0] pix_p;
    logic [NUM_CH-1:0][PIX_W-1:0] pix_r;
    sum_set_t                     acc_reg;
    sum_set_t                     added;
    sum_set_t                     snap_reg;
    logic                         pend_reg;
    logic                         accept;
    logic                         is_accum;
    logic                         frame_done;

    assign pix_p = {item.proc_c2, item.proc_c1, item.proc_c0};
    assign pix_r = {item.ref_c2, item.ref_c1, item.ref_c0};

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            added.proc[c] = sat_add(acc_reg.proc[c], pix_p[c]);
            added.refr[c] = sat_add(acc_reg.refr[c], pix_r[c]);
        end
    end

    // Hold off input while the command queue is full or a snapshot awaits its division
    assign full       = mid_full || pend_reg;
    assign accept     = push && !full;
    assign is_accum   = (item.operation == OP_ACCUM);
    assign frame_done = accept && is_accum && item.frame_end;

    assign mid_push      = accept && (!is_accum || item.frame_end);
    assign mid_data.kind = is_accum ? CMD_GAIN : CMD_CORRECT;
    assign mid_data.pix  = pix_p;
    assign snap          = snap_reg;

    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            snap_reg <= added;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (accept && is_accum)
            begin
                acc_reg <= item.frame_end ? '0 : added;
            end
            if (frame_done)
            begin
                pend_reg <= 1'b1;
            end
            else if (snap_free)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_frame_end_pend: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> pend_reg)
        else $error("frame end did not mark the snapshot pending");

    a_free_only_pend: assert property (@(posedge clk) disable iff (!rst_n)
        snap_free |-> pend_reg)
        else $error("snapshot released while none was pending");

    a_gain_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_push && (mid_data.kind == CMD_GAIN)) |-> !pend_reg)
        else $error("second gain command issued over a pending snapshot");
`endif

endmodule

`default_nettype wire

// ===== hdl/cmrg_div.sv =====
// Restoring divider producing one saturated gain quotient bit per cycle.
`default_nettype none

module cmrg_div #(
    parameter int GAIN_FRAC_BITS = cmrg_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cmrg_pkg::SUM_W-1:0]    numer,
    input  logic [cmrg_pkg::SUM_W-1:0]    denom,
    output logic                          done,
    output logic [cmrg_pkg::GAIN_W-1:0]   quot
);

    import cmrg_pkg::*;

    localparam int STEP_W = $clog2(GAIN_W + 1);

    typedef enum logic [2:0] {
        DV_IDLE = 3'b001,
        DV_RUN  = 3'b010,
        DV_DONE = 3'b100
    } dv_state_t;

    dv_state_t                 state_reg;
    dv_state_t                 state_next;
    logic [SUM_W+GAIN_W-1:0]   wide;
    logic                      sat_start;
    logic [SUM_W-1:0]          rem_reg;
    logic [SUM_W-1:0]          den_reg;
    logic [GAIN_W-1:0]         low_reg;
    logic [GAIN_W-1:0]         quot_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [SUM_W:0]            trial;
    logic [SUM_W:0]            diff;
    logic                      ge;

    // Numerator shifted into place; the top part is the initial remainder
    assign wide      = {{GAIN_W{1'b0}}, numer} << GAIN_FRAC_BITS;
    assign sat_start = (denom == '0) || (wide[SUM_W+GAIN_W-1:GAIN_W] >= denom);

    assign trial = {rem_reg, low_reg[GAIN_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    assign done = (state_reg == DV_DONE);
    assign quot = quot_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = sat_start ? DV_DONE : DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == DV_IDLE) && start)
        begin
            rem_reg  <= wide[SUM_W+GAIN_W-1:GAIN_W];
            low_reg  <= wide[GAIN_W-1:0];
            den_reg  <= denom;
            quot_reg <= sat_start ? GAIN_MAX : '0;
            step_reg <= STEP_W'(GAIN_W);
        end
        else if (state_reg == DV_RUN)
        begin
            rem_reg  <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            low_reg  <= {low_reg[GAIN_W-2:0], 1'b0};
            quot_reg <= {quot_reg[GAIN_W-2:0], ge};
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cmrg_back.sv =====
// Back end: runs gain updates through the divider and corrects pixels into the result queue.
`default_nettype none

module cmrg_back #(
    parameter int GAIN_FRAC_BITS = cmrg_pkg::GAIN_FRAC_BITS_DEF,
    parameter int RES_DEPTH      = cmrg_pkg::RES_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mid_empty,
    input  cmrg_pkg::cmd_t              mid_data,
    output logic                        mid_pop,
    input  cmrg_pkg::sum_set_t          snap,
    output logic                        snap_free,
    input  logic [$clog2(RES_DEPTH):0]  res_count,
    output logic                        res_push,
    output cmrg_pkg::out_item_t         res_data
);

    import cmrg_pkg::*;

    localparam int CNT_W = $clog2(RES_DEPTH) + 1;
    localparam logic [1:0] LAST_CH = 2'(NUM_CH - 1);
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(64'd1 << GAIN_FRAC_BITS);

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_START = 3'b010,
        BK_WAIT  = 3'b100
    } bk_state_t;

    bk_state_t                      state_reg;
    bk_state_t                      state_next;
    logic [1:0]                     ch_reg;
    logic [NUM_CH-1:0][GAIN_W-1:0]  gain_reg;
    logic                           s1_valid_reg;
    logic [NUM_CH-1:0][PROD_W-1:0]  prod_reg;
    logic [NUM_CH-1:0][PROD_W-1:0]  shifted;
    logic [NUM_CH-1:0][PIX_W-1:0]   clamped;
    logic                           room;
    logic                           is_gain;
    logic                           corr_go;
    logic                           div_start;
    logic                           div_done;
    logic [GAIN_W-1:0]              div_quot;

    assign room    = (CNT_W'(res_count) + CNT_W'(s1_valid_reg)) < CNT_W'(RES_DEPTH);
    assign is_gain = (mid_data.kind == CMD_GAIN);
    assign mid_pop = (state_reg == BK_IDLE) && !mid_empty && (is_gain || room);
    assign corr_go = mid_pop && !is_gain;

    assign div_start = (state_reg == BK_START);
    assign snap_free = (state_reg == BK_WAIT) && div_done && (ch_reg == LAST_CH);

    cmrg_div #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (snap.refr[ch_reg]),
        .denom (snap.proc[ch_reg]),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (mid_pop && is_gain)
                begin
                    state_next = BK_START;
                end
            end
            BK_START:
            begin
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (ch_reg == LAST_CH) ? BK_IDLE : BK_START;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Scale, drop the fraction bits and clamp to full scale
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            shifted[c] = prod_reg[c] >> GAIN_FRAC_BITS;
            clamped[c] = (|shifted[c][PROD_W-1:PIX_W]) ? PIX_MAX : shifted[c][PIX_W-1:0];
        end
    end

    assign res_push        = s1_valid_reg;
    assign res_data.out_c0 = clamped[0];
    assign res_data.out_c1 = clamped[1];
    assign res_data.out_c2 = clamped[2];

    always_ff @(posedge clk)
    begin
        if (corr_go)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                prod_reg[c] <= PROD_W'(mid_data.pix[c]) * PROD_W'(gain_reg[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            ch_reg       <= '0;
            gain_reg     <= {NUM_CH{GAIN_UNITY}};
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= corr_go;
            if (mid_pop && is_gain)
            begin
                ch_reg <= '0;
            end
            else if ((state_reg == BK_WAIT) && div_done)
            begin
                gain_reg[ch_reg] <= div_quot;
                if (ch_reg != LAST_CH)
                begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
        end
    end

`ifndef SYNTH
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (CNT_W'(res_count) < CNT_W'(RES_DEPTH)))
        else $error("corrected pixel written into a full result queue");

    a_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_WAIT) |=> $stable(gain_reg))
        else $error("gains changed outside a gain update");

    a_free_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        snap_free |=> (state_reg == BK_IDLE))
        else $error("back end did not return to idle after the last channel");
`endif

endmodule

`default_nettype wire

// ===== hdl/channel_mean_ratio_gain_correction_core.sv =====
// Top level of the per-channel mean-ratio gain correction core.
//
//  Channel  | Handshake          | Payload              | Transfer when
//  ---------+--------------------+----------------------+------------------------
//  input    | push / full        | item   (in_item_t)   | push high, full low
//  result   | empty / pop        | result (out_item_t)  | pop high, empty low
//
// A correct item is written into the command queue, registered through the
// per-channel multipliers and lands in the result queue, so results follow one per
// cycle while the back end is idle and the result queue has room. A frame-end pair
// launches three divisions on one shared restoring divider, one channel at a time;
// input is held off (full) until all three gains are written. Reset (rst_n,
// asynchronous) clears the sums, empties both queues and loads unity gains. Either
// side may stall freely: the command queue parts front and back, the result queue
// parts back and consumer.
`default_nettype none

module channel_mean_ratio_gain_correction_core #(
    parameter int GAIN_FRAC_BITS = cmrg_pkg::GAIN_FRAC_BITS_DEF,
    parameter int MID_DEPTH      = cmrg_pkg::MID_DEPTH_DEF,
    parameter int RES_DEPTH      = cmrg_pkg::RES_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  cmrg_pkg::in_item_t   item,
    output logic                 empty,
    input  logic                 pop,
    output cmrg_pkg::out_item_t  result
);

    import cmrg_pkg::*;

    // Command queue between front and back
    logic                        mid_push;
    logic                        mid_pop;
    logic                        mid_full;
    logic                        mid_empty;
    cmd_t                        mid_wr;
    logic [$bits(cmd_t)-1:0]     mid_rd;
    logic [$clog2(MID_DEPTH):0]  mid_count;

    // Snapshot of the frame sums handed to the back end
    sum_set_t                    snap;
    logic                        snap_free;

    // Result queue
    logic                          res_push;
    out_item_t                     res_wr;
    logic [$bits(out_item_t)-1:0]  res_rd;
    logic                          res_full;
    logic [$clog2(RES_DEPTH):0]    res_count;

    cmrg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_data  (mid_wr),
        .snap      (snap),
        .snap_free (snap_free)
    );

    cmrg_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_wr),
        .rd_en   (mid_pop),
        .rd_data (mid_rd),
        .full    (mid_full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    cmrg_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .RES_DEPTH      (RES_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_data  (cmd_t'(mid_rd)),
        .mid_pop   (mid_pop),
        .snap      (snap),
        .snap_free (snap_free),
        .res_count (res_count),
        .res_push  (res_push),
        .res_data  (res_wr)
    );

    // The back end reserves room before it launches a correction, so the
    // result queue never overflows; res_full only feeds the checks below.
    cmrg_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .rd_en   (pop),
        .rd_data (res_rd),
        .full    (res_full),
        .empty   (empty),
        .count   (res_count)
    );

    assign result = out_item_t'(res_rd);

`ifndef SYNTH
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result transfer into a full result queue");

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (mid_count < ($clog2(MID_DEPTH)+1)'(MID_DEPTH)))
        else $error("command written into a full command queue");

    a_full_during_update: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && (item.operation == OP_ACCUM) && item.frame_end) |=> full)
        else $error("input not held off after a frame end");
`endif

endmodule

`default_nettype wire
